// ----- src/sle_pkg.sv -----
`timescale 1ns / 1ps

package sle_pkg;

    localparam int KEY_W = 32;

    localparam logic [1:0] CMD_INSERT = 2'd0;
    localparam logic [1:0] CMD_DELETE = 2'd1;
    localparam logic [1:0] CMD_SEARCH = 2'd2;

    localparam logic [1:0] STATUS_OK   = 2'd0;
    localparam logic [1:0] STATUS_MISS = 2'd1;
    localparam logic [1:0] STATUS_FULL = 2'd2;

    typedef struct packed {
        logic cmp_en;
        logic ins_en;
        logic del_en;
    } cell_ctrl_t;

endpackage

// ----- src/sle_cell.sv -----
`timescale 1ns / 1ps

module sle_cell (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  sle_pkg::cell_ctrl_t        ctrl,
    input  logic [sle_pkg::KEY_W-1:0]  key_in,
    input  logic [sle_pkg::KEY_W-1:0]  left_key,
    input  logic                       left_valid,
    input  logic                       left_lt,
    input  logic [sle_pkg::KEY_W-1:0]  right_key,
    input  logic                       right_valid,
    output logic [sle_pkg::KEY_W-1:0]  key_out,
    output logic                       valid_out,
    output logic                       lt_out,
    output logic                       eq_out
);

    logic [sle_pkg::KEY_W-1:0] key_reg;
    logic [sle_pkg::KEY_W-1:0] key_next;
    logic                      valid_reg;
    logic                      valid_next;
    logic                      lt_reg;
    logic                      lt_next;
    logic                      eq_reg;
    logic                      eq_next;

    always_comb begin
        lt_next    = valid_reg && ($signed(key_reg) < $signed(key_in));
        eq_next    = valid_reg && (key_reg == key_in);
        key_next   = key_reg;
        valid_next = valid_reg;
        if (ctrl.ins_en && !lt_reg) begin
            if (left_lt) begin
                key_next   = key_in;
                valid_next = 1'b1;
            end else begin
                key_next   = left_key;
                valid_next = left_valid;
            end
        end else if (ctrl.del_en && !lt_reg) begin
            key_next   = right_key;
            valid_next = right_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
            lt_reg    <= 1'b0;
            eq_reg    <= 1'b0;
        end else begin
            valid_reg <= valid_next;
            if (ctrl.cmp_en) begin
                lt_reg <= lt_next;
                eq_reg <= eq_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        key_reg <= key_next;
    end

    assign key_out   = key_reg;
    assign valid_out = valid_reg;
    assign lt_out    = lt_reg;
    assign eq_out    = eq_reg;

endmodule

// ----- src/sorted_list_engine.sv -----
`timescale 1ns / 1ps
// A request word is accepted only in the idle state, so the next one waits until this
// one has applied. Every cell compares its key in the compare state and the row shifts
// its keys toward or away from the slot in the apply state, which registers the result.
// A waiting result word lets the next request in but holds its apply step until taken.
// Reset clears the entry count, the cell valid bits and the handshake state.

module sorted_list_engine #(
    parameter int CAPACITY = 16
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [1:0]  s_cmd,
    input  logic signed [31:0] s_value,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [1:0]  m_status,
    output logic [3:0]  m_position,
    output logic [4:0]  m_entry_count
);

    localparam int IW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CW = $clog2(CAPACITY + 1);

    typedef enum logic [2:0] {
        ST_IDLE  = 3'b001,
        ST_CMP   = 3'b010,
        ST_APPLY = 3'b100
    } state_t;

    state_t                    state_reg;
    state_t                    state_next;
    logic [1:0]                cmd_reg;
    logic [sle_pkg::KEY_W-1:0] value_reg;
    logic [CW-1:0]             count_reg;
    logic [CW-1:0]             count_next;
    logic                      m_valid_reg;
    logic [1:0]                m_status_reg;
    logic [1:0]                m_status_next;
    logic [3:0]                m_position_reg;
    logic [3:0]                m_position_next;
    logic [4:0]                m_count_reg;

    sle_pkg::cell_ctrl_t       ctrl;

    logic [sle_pkg::KEY_W-1:0] key_vec   [CAPACITY];
    logic [sle_pkg::KEY_W-1:0] lkey_vec  [CAPACITY];
    logic [sle_pkg::KEY_W-1:0] rkey_vec  [CAPACITY];
    logic [CAPACITY-1:0]       valid_vec;
    logic [CAPACITY-1:0]       lvalid_vec;
    logic [CAPACITY-1:0]       rvalid_vec;
    logic [CAPACITY-1:0]       lt_vec;
    logic [CAPACITY-1:0]       llt_vec;
    logic [CAPACITY-1:0]       eq_vec;
    logic [CAPACITY-1:0]       leq_vec;
    logic [CAPACITY-1:0]       first_ge;
    logic [CAPACITY-1:0]       first_eq;

    logic                      fire;
    logic                      full;
    logic                      found;
    logic [IW-1:0]             ins_pos;
    logic [IW-1:0]             hit_pos;

    genvar g;
    generate
        for (g = 0; g < CAPACITY; g++) begin : g_cell
            if (g == 0) begin : g_first
                assign lkey_vec[g]   = value_reg;
                assign lvalid_vec[g] = 1'b1;
                assign llt_vec[g]    = 1'b1;
                assign leq_vec[g]    = 1'b0;
            end else begin : g_mid
                assign lkey_vec[g]   = key_vec[g-1];
                assign lvalid_vec[g] = valid_vec[g-1];
                assign llt_vec[g]    = lt_vec[g-1];
                assign leq_vec[g]    = eq_vec[g-1];
            end
            if (g == CAPACITY - 1) begin : g_last
                assign rkey_vec[g]   = value_reg;
                assign rvalid_vec[g] = 1'b0;
            end else begin : g_inner
                assign rkey_vec[g]   = key_vec[g+1];
                assign rvalid_vec[g] = valid_vec[g+1];
            end

            assign first_ge[g] = !lt_vec[g] && llt_vec[g];
            assign first_eq[g] = eq_vec[g] && !leq_vec[g];

            sle_cell u_cell (
                .aclk        (aclk),
                .aresetn     (aresetn),
                .ctrl        (ctrl),
                .key_in      (value_reg),
                .left_key    (lkey_vec[g]),
                .left_valid  (lvalid_vec[g]),
                .left_lt     (llt_vec[g]),
                .right_key   (rkey_vec[g]),
                .right_valid (rvalid_vec[g]),
                .key_out     (key_vec[g]),
                .valid_out   (valid_vec[g]),
                .lt_out      (lt_vec[g]),
                .eq_out      (eq_vec[g])
            );
        end
    endgenerate

    always_comb begin
        ins_pos = '0;
        hit_pos = '0;
        for (int i = 0; i < CAPACITY; i++) begin
            if (first_ge[i]) begin
                ins_pos = ins_pos | IW'(i);
            end
            if (first_eq[i]) begin
                hit_pos = hit_pos | IW'(i);
            end
        end
    end

    assign fire  = (state_reg == ST_APPLY) && (!m_valid_reg || m_ready);
    assign full  = (count_reg == CW'(CAPACITY));
    assign found = |eq_vec;

    always_comb begin
        ctrl.cmp_en     = (state_reg == ST_CMP);
        ctrl.ins_en     = 1'b0;
        ctrl.del_en     = 1'b0;
        count_next      = count_reg;
        m_status_next   = sle_pkg::STATUS_MISS;
        m_position_next = 4'd0;
        case (cmd_reg)
            sle_pkg::CMD_INSERT: begin
                if (full) begin
                    m_status_next = sle_pkg::STATUS_FULL;
                end else begin
                    m_status_next   = sle_pkg::STATUS_OK;
                    m_position_next = 4'(ins_pos);
                    count_next      = count_reg + CW'(1);
                    ctrl.ins_en     = fire;
                end
            end
            sle_pkg::CMD_DELETE: begin
                if (found) begin
                    m_status_next   = sle_pkg::STATUS_OK;
                    m_position_next = 4'(hit_pos);
                    count_next      = count_reg - CW'(1);
                    ctrl.del_en     = fire;
                end
            end
            sle_pkg::CMD_SEARCH: begin
                if (found) begin
                    m_status_next   = sle_pkg::STATUS_OK;
                    m_position_next = 4'(hit_pos);
                end
            end
            default: begin
                m_status_next = sle_pkg::STATUS_MISS;
            end
        endcase
    end

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    state_next = ST_CMP;
                end
            end
            ST_CMP: begin
                state_next = ST_APPLY;
            end
            ST_APPLY: begin
                if (fire) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            count_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (fire) begin
                count_reg   <= count_next;
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            cmd_reg   <= s_cmd;
            value_reg <= s_value;
        end
        if (fire) begin
            m_status_reg   <= m_status_next;
            m_position_reg <= m_position_next;
            m_count_reg    <= 5'(count_next);
        end
    end

    assign s_ready       = (state_reg == ST_IDLE);
    assign m_valid       = m_valid_reg;
    assign m_status      = m_status_reg;
    assign m_position    = m_position_reg;
    assign m_entry_count = m_count_reg;

endmodule

// ----- src/sle_checker.sv -----
`timescale 1ns / 1ps

module sle_checker #(
    parameter int CAPACITY = 16
) (
    input logic       aclk,
    input logic       aresetn,
    input logic       m_valid,
    input logic       m_ready,
    input logic [1:0] m_status,
    input logic [3:0] m_position,
    input logic [4:0] m_entry_count
);

    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_status) && $stable(m_position)
            && $stable(m_entry_count))
        else $error("Result word changed while stalled.");

    a_status_legal: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_status == sle_pkg::STATUS_OK || m_status == sle_pkg::STATUS_MISS
            || m_status == sle_pkg::STATUS_FULL))
        else $error("Result word carries an unused status code.");

    a_miss_position: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_status != sle_pkg::STATUS_OK |-> m_position == 4'd0)
        else $error("Failed request reports a nonzero position.");

    a_full_count: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_status == sle_pkg::STATUS_FULL |-> m_entry_count == 5'(CAPACITY))
        else $error("Full status reported while the table is not full.");

endmodule

bind sorted_list_engine sle_checker #(.CAPACITY(CAPACITY)) u_sle_checker (
    .aclk          (aclk),
    .aresetn       (aresetn),
    .m_valid       (m_valid),
    .m_ready       (m_ready),
    .m_status      (m_status),
    .m_position    (m_position),
    .m_entry_count (m_entry_count)
);
